// File: hdl/unt_pkg.sv
// Shared types, constants and command/status codes for the unique name table.
`default_nettype none
package unt_pkg;
    localparam int ENTRIES_DEF = 8;
    localparam int NAME_W      = 152;
    localparam int SLOT_W      = 6;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LIST   = 2'd1;
    localparam logic [1:0] CMD_SORT   = 2'd2;
    localparam logic [1:0] CMD_DELETE = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_SORT_CHG  = 3'd5;
    localparam logic [2:0] ST_SORT_SAME = 3'd6;
    localparam logic [2:0] ST_LIST      = 3'd7;

    // store write data select
    localparam logic [1:0] WS_KEY = 2'd0;
    localparam logic [1:0] WS_A   = 2'd1;
    localparam logic [1:0] WS_B   = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [23:0] key_word2;
    } t_cmd_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        list_empty;
        logic [5:0]  slot;
        logic [63:0] out_word0;
        logic [63:0] out_word1;
        logic [23:0] out_word2;
        logic        last;
    } t_result;
endpackage
`default_nettype wire

// File: hdl/unt_if.sv
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface unt_cmd_if import unt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cmd_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface unt_res_if import unt_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/unt_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module unt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: hdl/unt_datapath.sv
// Datapath: key and scratch registers, valid bits, name store RAM, comparators.
`default_nettype none
module unt_datapath import unt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IW      = $clog2(ENTRIES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load_key,
    input  wire t_cmd_item        i_item,
    input  wire logic [IW-1:0]    i_addr,
    input  wire logic             i_we,
    input  wire logic [1:0]       i_wsel,      // 0 key, 1 hold A, 2 hold B
    input  wire logic             i_cap_a,
    input  wire logic             i_cap_b,
    input  wire logic             i_set_valid,
    input  wire logic             i_clr_valid,
    input  wire logic [IW-1:0]    i_vaddr,
    output logic [NAME_W-1:0]     o_rdata,
    output logic [ENTRIES-1:0]    o_valid,
    output logic                  o_rd_eq_key,
    output logic                  o_a_gt_rd
);
    logic [NAME_W-1:0]  r_key;
    logic [NAME_W-1:0]  r_a;
    logic [NAME_W-1:0]  r_b;
    logic [ENTRIES-1:0] r_valid;
    logic [NAME_W-1:0]  n_wdata;

    always_ff @(posedge i_clk) begin
        if (i_load_key) begin
            r_key <= {i_item.key_word0, i_item.key_word1, i_item.key_word2};
        end
        if (i_cap_a) begin
            r_a <= o_rdata;
        end
        if (i_cap_b) begin
            r_b <= o_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_set_valid) begin
            r_valid[i_vaddr] <= 1'b1;
        end else if (i_clr_valid) begin
            r_valid[i_vaddr] <= 1'b0;
        end
    end

    always_comb begin
        case (i_wsel)
            WS_KEY:  n_wdata = r_key;
            WS_A:    n_wdata = r_a;
            default: n_wdata = r_b;
        endcase
    end

    unt_ram #(.WIDTH(NAME_W), .DEPTH(ENTRIES)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_we),
        .i_addr (i_addr),
        .i_wdata(n_wdata),
        .o_rdata(o_rdata)
    );

    assign o_valid     = r_valid;
    assign o_rd_eq_key = (o_rdata == r_key);
    assign o_a_gt_rd   = (r_a > o_rdata);
endmodule
`default_nettype wire

// File: hdl/unt_ctrl.sv
// Controller: command sequencing, scans, exchange sort and result register.
`default_nettype none
module unt_ctrl import unt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IW      = $clog2(ENTRIES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    unt_cmd_if.sink            cmd,
    unt_res_if.source          res,
    output logic               o_load_key,
    output logic [IW-1:0]      o_addr,
    output logic               o_we,
    output logic [1:0]         o_wsel,
    output logic               o_cap_a,
    output logic               o_cap_b,
    output logic               o_set_valid,
    output logic               o_clr_valid,
    output logic [IW-1:0]      o_vaddr,
    input  wire logic [NAME_W-1:0]  i_rdata,
    input  wire logic [ENTRIES-1:0] i_valid,
    input  wire logic          i_rd_eq_key,
    input  wire logic          i_a_gt_rd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;  // insert duplicate / delete search
    localparam logic [3:0] S_CHK    = 4'd2;
    localparam logic [3:0] S_LRD    = 4'd3;  // list read
    localparam logic [3:0] S_LOUT   = 4'd4;
    localparam logic [3:0] S_PACK   = 4'd5;  // sort: compact valid entries
    localparam logic [3:0] S_PCHK   = 4'd6;
    localparam logic [3:0] S_IRD    = 4'd7;  // sort: read slot i into A
    localparam logic [3:0] S_JRD    = 4'd8;
    localparam logic [3:0] S_JCMP   = 4'd9;
    localparam logic [3:0] S_IWR    = 4'd10;
    localparam logic [3:0] S_CLR    = 4'd11; // sort: free slots past the packed entries
    localparam logic [3:0] S_RES    = 4'd12;
    localparam logic [3:0] S_WAIT   = 4'd13;

    localparam int CW = IW + 1;
    localparam logic [CW-1:0] NENT = CW'(ENTRIES);

    logic [3:0]    r_state, n_state;
    logic [1:0]    r_cmd, n_cmd;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_n, n_n;
    logic [IW-1:0] r_free, n_free;
    logic          r_hit, n_hit;
    logic          r_chg, n_chg;
    logic          r_any, n_any;
    logic          r_rv, n_rv;
    t_result       r_res, n_res;
    logic          r_ovalid, n_ovalid;

    logic          full;
    logic [IW-1:0] first_free;
    logic          later_valid;

    always_comb begin
        full = &i_valid;
        first_free = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (!i_valid[k]) begin
                first_free = IW'(k);
            end
        end
        later_valid = 1'b0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (CW'(k) > r_i && i_valid[k]) begin
                later_valid = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_i = r_i; n_j = r_j; n_n = r_n;
        n_free = r_free; n_hit = r_hit; n_chg = r_chg; n_any = r_any;
        n_rv = r_rv; n_res = r_res; n_ovalid = r_ovalid;
        o_load_key = 1'b0; o_addr = r_i[IW-1:0]; o_we = 1'b0; o_wsel = WS_KEY;
        o_cap_a = 1'b0; o_cap_b = 1'b0; o_set_valid = 1'b0; o_clr_valid = 1'b0;
        o_vaddr = r_i[IW-1:0];
        cmd.ready = 1'b0;
        if (r_ovalid && res.ready) begin
            n_ovalid = 1'b0;
        end
        n_res.list_empty = r_res.list_empty;
        case (r_state)
            S_IDLE: begin
                cmd.ready = 1'b1;
                if (cmd.valid) begin
                    o_load_key = 1'b1;
                    n_cmd = cmd.data.cmd; n_i = '0; n_hit = 1'b0; n_any = 1'b0;
                    n_chg = 1'b0; n_n = '0; n_free = first_free;
                    n_res = '0; n_res.last = 1'b1;
                    case (cmd.data.cmd)
                        CMD_INSERT: begin
                            if (full) begin
                                n_res.status = ST_FULL;
                                n_state = S_WAIT; n_ovalid = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_DELETE: n_state = S_SCAN;
                        CMD_LIST:   n_state = S_LRD;
                        default:    n_state = S_PACK;
                    endcase
                end
            end
            S_SCAN: begin
                n_rv = i_valid[r_i[IW-1:0]];
                n_state = S_CHK;
            end
            S_CHK: begin
                o_addr = r_i[IW-1:0];
                if (r_rv && i_rd_eq_key) begin
                    if (r_cmd == CMD_DELETE) begin
                        o_clr_valid = 1'b1;
                        if (!r_hit) begin
                            n_res.slot = SLOT_W'(r_i);
                        end
                    end
                    n_hit = 1'b1;
                end
                if (r_i == NENT - 1'b1) begin
                    n_state = S_WAIT; n_ovalid = 1'b1;
                    if (r_cmd == CMD_INSERT) begin
                        if (r_hit || (r_rv && i_rd_eq_key)) begin
                            n_res.status = ST_DUPLICATE;
                        end else begin
                            o_we = 1'b1; o_addr = r_free; o_wsel = WS_KEY;
                            o_set_valid = 1'b1; o_vaddr = r_free;
                            n_res.status = ST_INSERTED;
                            n_res.slot = SLOT_W'(r_free);
                        end
                    end else begin
                        n_res.status = (r_hit || (r_rv && i_rd_eq_key)) ?
                                       ST_DELETED : ST_NOT_FOUND;
                    end
                end else begin
                    n_i = r_i + 1'b1; n_state = S_SCAN;
                end
            end
            S_LRD: begin
                if (r_i == NENT) begin
                    if (!r_any) begin
                        n_res = '0; n_res.status = ST_LIST; n_res.list_empty = 1'b1;
                        n_res.last = 1'b1; n_ovalid = 1'b1;
                    end
                    n_state = S_WAIT;
                end else if (i_valid[r_i[IW-1:0]]) begin
                    n_state = S_LOUT;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_LOUT: begin
                if (!r_ovalid || res.ready) begin
                    n_res.status = ST_LIST; n_res.list_empty = 1'b0;
                    n_res.slot = SLOT_W'(r_i);
                    {n_res.out_word0, n_res.out_word1, n_res.out_word2} = i_rdata;
                    n_res.last = !later_valid;
                    n_ovalid = 1'b1; n_any = 1'b1;
                    n_i = r_i + 1'b1;
                    n_state = later_valid ? S_LRD : S_WAIT;
                end
            end
            S_PACK: begin
                // r_i source slot, r_n destination count
                if (r_i == NENT) begin
                    n_i = '0; n_j = CW'(1);
                    n_state = (r_n > CW'(1)) ? S_IRD : S_CLR;
                    if (r_n <= CW'(1)) begin
                        n_i = r_n;
                    end
                end else if (i_valid[r_i[IW-1:0]]) begin
                    n_state = S_PCHK;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_PCHK: begin
                o_cap_a = 1'b1;
                n_state = S_IWR;
                n_j = r_i;
            end
            S_IWR: begin
                if (r_j == NENT) begin
                    // end of sort pass on slot r_i: write A back
                    o_we = 1'b1; o_addr = r_i[IW-1:0]; o_wsel = WS_A;
                    if (r_i + CW'(2) >= r_n) begin
                        n_i = r_n; n_state = S_CLR;
                    end else begin
                        n_i = r_i + 1'b1; n_state = S_IRD;
                    end
                end else begin
                    // packing move of slot r_j to slot r_n
                    o_we = 1'b1; o_addr = r_n[IW-1:0]; o_wsel = WS_A;
                    o_set_valid = 1'b1; o_vaddr = r_n[IW-1:0];
                    if (r_j != r_n) begin
                        n_chg = 1'b1;
                    end
                    n_n = r_n + 1'b1;
                    n_i = r_j + 1'b1;
                    n_state = S_PACK;
                end
            end
            S_IRD: begin
                o_addr = r_i[IW-1:0];
                n_j = r_i + 1'b1;
                n_state = S_JRD;
            end
            S_JRD: begin
                o_cap_a = (r_j == r_i + 1'b1);
                o_addr = r_j[IW-1:0];
                n_state = S_JCMP;
            end
            S_JCMP: begin
                o_addr = r_j[IW-1:0];
                if (i_a_gt_rd) begin
                    o_cap_b = 1'b1;
                    o_we = 1'b1; o_wsel = WS_A;
                    n_chg = 1'b1;
                    n_state = S_JRD;
                    n_rv = 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
                if (!i_a_gt_rd) begin
                    if (r_j + 1'b1 == r_n) begin
                        n_j = NENT; n_state = S_IWR;
                    end else begin
                        n_j = r_j + 1'b1; n_state = S_JRD;
                    end
                end else begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                // swapped: A takes the smaller name, old slot j still on the read port
                o_wsel = WS_B;
                o_cap_a = 1'b1;
                if (r_j + 1'b1 == r_n) begin
                    n_j = NENT; n_state = S_IWR;
                end else begin
                    n_j = r_j + 1'b1; n_state = S_JRD;
                end
            end
            S_CLR: begin
                if (r_i == NENT) begin
                    n_res.status = r_chg ? ST_SORT_CHG : ST_SORT_SAME;
                    n_ovalid = 1'b1; n_state = S_WAIT;
                end else begin
                    o_we = 1'b1; o_addr = r_i[IW-1:0]; o_wsel = WS_B;
                    if (i_valid[r_i[IW-1:0]]) begin
                        n_chg = 1'b1;
                    end
                    o_clr_valid = 1'b1; o_vaddr = r_i[IW-1:0];
                    n_i = r_i + 1'b1;
                end
            end
            S_WAIT: begin
                if (!r_ovalid || res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid;
        end
        r_cmd <= n_cmd; r_i <= n_i; r_j <= n_j; r_n <= n_n; r_free <= n_free;
        r_hit <= n_hit; r_chg <= n_chg; r_any <= n_any; r_rv <= n_rv;
        r_res <= n_res;
    end

    assign res.valid = r_ovalid;
    assign res.data  = r_res;

    a_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ready |-> r_state == S_IDLE) else $error("command taken while busy");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !res.ready) |=> r_ovalid) else $error("result dropped");
    a_one_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_set_valid && o_clr_valid)) else $error("valid set and cleared");
endmodule
`default_nettype wire

// File: hdl/unique_name_table.sv
// Top level of the unique name table.
//   channel   dir  handshake     payload
//   cmd       in   valid/ready   cmd, key_word0..2
//   res       out  valid/ready   status, list_empty, slot, out_word0..2, last
// One command at a time; insert (unless the table is full) and delete scan every slot
// through S_SCAN and S_CHK. List reads each slot and returns the valid ones; sort packs
// and then runs an exchange sort over the single RAM port.
// Synchronous active-low reset empties the table; store contents stay unset.
// A stalled result holds the controller until it is taken.
`default_nettype none
module unique_name_table import unt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    unt_cmd_if.sink   cmd,
    unt_res_if.source res
);
    localparam int IW = $clog2(ENTRIES);

    logic              load_key, we, cap_a, cap_b, set_v, clr_v, eq, gt;
    logic [IW-1:0]     addr, vaddr;
    logic [1:0]        wsel;
    logic [NAME_W-1:0] rdata;
    logic [ENTRIES-1:0] valid;

    unt_ctrl #(.ENTRIES(ENTRIES), .IW(IW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cmd(cmd), .res(res),
        .o_load_key(load_key), .o_addr(addr), .o_we(we), .o_wsel(wsel),
        .o_cap_a(cap_a), .o_cap_b(cap_b), .o_set_valid(set_v),
        .o_clr_valid(clr_v), .o_vaddr(vaddr), .i_rdata(rdata),
        .i_valid(valid), .i_rd_eq_key(eq), .i_a_gt_rd(gt)
    );

    unt_datapath #(.ENTRIES(ENTRIES), .IW(IW)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load_key(load_key), .i_item(cmd.data),
        .i_addr(addr), .i_we(we), .i_wsel(wsel), .i_cap_a(cap_a),
        .i_cap_b(cap_b), .i_set_valid(set_v), .i_clr_valid(clr_v),
        .i_vaddr(vaddr), .o_rdata(rdata), .o_valid(valid),
        .o_rd_eq_key(eq), .o_a_gt_rd(gt)
    );
endmodule
`default_nettype wire

// File: tb/unique_name_table_tb.sv
// Self-checking testbench for the unique name table: directed and random commands against a behavioural table.
`default_nettype none
module unique_name_table_tb;
    import unt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS = ENTRIES_DEF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    unt_cmd_if cmd_ch ();
    unt_res_if res_ch ();

    unique_name_table #(.ENTRIES(N_SLOTS)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .cmd    (cmd_ch.sink),
        .res    (res_ch.source)
    );

    always #1 i_clk = ~i_clk;

    typedef logic [NAME_W-1:0] t_name;

    t_name     table_names [N_SLOTS];
    logic      table_used [N_SLOTS];
    t_cmd_item pending_cmds [$];
    t_result   expected_results [$];
    t_name     name_pool [$];
    int        errors = 0;
    bit        stim_done = 1'b0;
    bit        quiet_snk = 1'b0;
    int        hold_left = 0;

    function automatic t_result blank_result(logic [2:0] st, int slot);
        t_result r;
        r = '0;
        r.status = st;
        r.slot = slot[5:0];
        r.last = 1'b1;
        return r;
    endfunction

    // Applies one command to the behavioural table and queues its results.
    task automatic predict_table(t_cmd_item c);
        t_name key;
        t_name packed_names [N_SLOTS];
        t_name tmp;
        t_result r;
        int free_slot;
        int hit;
        int lastidx;
        int n;
        bit changed;
        bit v;
        key = {c.key_word0, c.key_word1, c.key_word2};
        case (c.cmd)
            CMD_INSERT: begin
                free_slot = -1;
                for (int i = N_SLOTS - 1; i >= 0; i--)
                    if (!table_used[i]) free_slot = i;
                hit = 0;
                for (int i = 0; i < N_SLOTS; i++)
                    if (table_used[i] && table_names[i] == key) hit = 1;
                if (free_slot < 0) begin
                    expected_results.push_back(blank_result(ST_FULL, 0));
                end else if (hit) begin
                    expected_results.push_back(blank_result(ST_DUPLICATE, 0));
                end else begin
                    table_names[free_slot] = key;
                    table_used[free_slot] = 1'b1;
                    expected_results.push_back(blank_result(ST_INSERTED, free_slot));
                end
            end
            CMD_LIST: begin
                lastidx = -1;
                for (int i = 0; i < N_SLOTS; i++)
                    if (table_used[i]) lastidx = i;
                if (lastidx < 0) begin
                    r = blank_result(ST_LIST, 0);
                    r.list_empty = 1'b1;
                    expected_results.push_back(r);
                end else begin
                    for (int i = 0; i < N_SLOTS; i++) begin
                        if (table_used[i]) begin
                            r = blank_result(ST_LIST, i);
                            {r.out_word0, r.out_word1, r.out_word2} = table_names[i];
                            r.last = (i == lastidx);
                            expected_results.push_back(r);
                        end
                    end
                end
            end
            CMD_SORT: begin
                n = 0;
                changed = 1'b0;
                for (int i = 0; i < N_SLOTS; i++)
                    if (table_used[i]) begin
                        packed_names[n] = table_names[i];
                        n++;
                    end
                for (int i = 0; i + 1 < n; i++)
                    for (int j = i + 1; j < n; j++)
                        if (packed_names[i] > packed_names[j]) begin
                            tmp = packed_names[i];
                            packed_names[i] = packed_names[j];
                            packed_names[j] = tmp;
                        end
                for (int i = 0; i < N_SLOTS; i++) begin
                    v = (i < n);
                    if (v != table_used[i] || (v && packed_names[i] != table_names[i]))
                        changed = 1'b1;
                    table_used[i] = v;
                    table_names[i] = v ? packed_names[i] : '0;
                end
                expected_results.push_back(
                    blank_result(changed ? ST_SORT_CHG : ST_SORT_SAME, 0));
            end
            default: begin
                hit = -1;
                for (int i = 0; i < N_SLOTS; i++)
                    if (table_used[i] && table_names[i] == key) begin
                        table_used[i] = 1'b0;
                        if (hit < 0) hit = i;
                    end
                expected_results.push_back(hit < 0 ? blank_result(ST_NOT_FOUND, 0)
                                                   : blank_result(ST_DELETED, hit));
            end
        endcase
    endtask

    function automatic t_name random_name();
        t_name k;
        k = NAME_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        // usually a short string, zero padded after a random length
        if ($urandom_range(0, 3) != 0)
            k = k & ~({NAME_W{1'b1}} >> ($urandom_range(1, 19) * 8));
        return k;
    endfunction

    function automatic t_cmd_item make_cmd(logic [1:0] op, t_name k);
        t_cmd_item c;
        c.cmd = op;
        {c.key_word0, c.key_word1, c.key_word2} = k;
        return c;
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data <= '0;
        end else if (!cmd_ch.valid || cmd_ch.ready) begin
            if (pending_cmds.size() > 0
                    && (stim_done || $urandom_range(0, 99) >= 23 || $time < 400)) begin
                cmd_ch.data <= pending_cmds[0];
                predict_table(pending_cmds.pop_front());
                cmd_ch.valid <= 1'b1;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result status=%0d", res_ch.data.status);
                    errors++;
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (res_ch.data.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, res_ch.data.status);
                        errors++;
                    end
                    if (res_ch.data.list_empty !== e.list_empty) begin
                        $error("list_empty exp %0d got %0d", e.list_empty,
                               res_ch.data.list_empty);
                        errors++;
                    end
                    if (res_ch.data.slot !== e.slot) begin
                        $error("slot exp %0d got %0d", e.slot, res_ch.data.slot);
                        errors++;
                    end
                    if (res_ch.data.out_word0 !== e.out_word0) begin
                        $error("out_word0 exp %h got %h", e.out_word0, res_ch.data.out_word0);
                        errors++;
                    end
                    if (res_ch.data.out_word1 !== e.out_word1) begin
                        $error("out_word1 exp %h got %h", e.out_word1, res_ch.data.out_word1);
                        errors++;
                    end
                    if (res_ch.data.out_word2 !== e.out_word2) begin
                        $error("out_word2 exp %h got %h", e.out_word2, res_ch.data.out_word2);
                        errors++;
                    end
                    if (res_ch.data.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, res_ch.data.last);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                res_ch.ready <= 1'b0;
            end else if (quiet_snk) begin
                hold_left <= 300;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= stim_done || $time < 400 || $urandom_range(0, 99) >= 23;
            end
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || cmd_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_name k;
        logic [1:0] op;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        res_ch.ready = 1'b0;
        for (int i = 0; i < N_SLOTS; i++) begin
            table_used[i] = 1'b0;
            table_names[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, extremes, fill up, duplicate, full, sort, delete
        pending_cmds.push_back(make_cmd(CMD_LIST, '0));
        pending_cmds.push_back(make_cmd(CMD_SORT, '0));
        pending_cmds.push_back(make_cmd(CMD_DELETE, '1));
        pending_cmds.push_back(make_cmd(CMD_INSERT, '1));
        pending_cmds.push_back(make_cmd(CMD_INSERT, '0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, '1));
        pending_cmds.push_back(make_cmd(CMD_INSERT, {8'h41, 144'h0}));
        pending_cmds.push_back(make_cmd(CMD_INSERT, {8'h41, 136'h0, 8'h01}));
        pending_cmds.push_back(make_cmd(CMD_INSERT, {8'h41, 8'h00, 8'h42, 128'h0}));
        pending_cmds.push_back(make_cmd(CMD_INSERT, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 24'h0}));
        pending_cmds.push_back(make_cmd(CMD_INSERT, {128'h0, 24'hFF_FFFF}));
        pending_cmds.push_back(make_cmd(CMD_INSERT, {8'h20, 144'h0}));
        pending_cmds.push_back(make_cmd(CMD_INSERT, {8'h30, 144'h0}));
        pending_cmds.push_back(make_cmd(CMD_LIST, '0));
        pending_cmds.push_back(make_cmd(CMD_SORT, '0));
        pending_cmds.push_back(make_cmd(CMD_SORT, '0));
        pending_cmds.push_back(make_cmd(CMD_LIST, '0));
        pending_cmds.push_back(make_cmd(CMD_DELETE, '0));
        pending_cmds.push_back(make_cmd(CMD_DELETE, {8'h41, 144'h0}));
        pending_cmds.push_back(make_cmd(CMD_LIST, '0));
        pending_cmds.push_back(make_cmd(CMD_SORT, '0));
        pending_cmds.push_back(make_cmd(CMD_LIST, '0));
        wait_drained();

        // sender pause until drained, then a long receiver hold while commands queue up
        quiet_snk = 1'b1;
        wait (hold_left > 0);
        quiet_snk = 1'b0;
        for (int i = 0; i < 20; i++)
            pending_cmds.push_back(make_cmd(i % 3 == 0 ? CMD_LIST : CMD_INSERT, random_name()));
        wait_drained();

        for (int n = 0; n < 250; n++) begin
            if (name_pool.size() > 0 && $urandom_range(0, 1))
                k = name_pool[$urandom_range(0, name_pool.size() - 1)];
            else begin
                k = random_name();
                name_pool.push_back(k);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = CMD_INSERT;
                4, 5:       op = CMD_LIST;
                6:          op = CMD_SORT;
                default:    op = CMD_DELETE;
            endcase
            pending_cmds.push_back(make_cmd(op, k));
            // mid-stream pause: everything sent so far completes first
            if (n == 120) begin
                wait_drained();
            end
        end
        stim_done = 1'b1;
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hdl/unt_pkg.sv
hdl/unt_if.sv
hdl/unt_ram.sv
hdl/unt_datapath.sv
hdl/unt_ctrl.sv
hdl/unique_name_table.sv
tb/unique_name_table_tb.sv
